// ----- rtl/core/lgs_pkg.sv -----
// Package for the life grid generation step block.
// Holds the request codes, the per-row command struct and the fixed field widths.
// Used by lgs_row_cell, life_grid_generation_step and lgs_checker.
`default_nettype none

package lgs_pkg;

  // Default grid side
  localparam int GRID_SIZE_DEF = 32;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 5;
  localparam int ROW_OUT_W = 32;
  localparam int IN_DATA_W  = 16;  // row, col packed, filled up to whole bytes
  localparam int IN_USER_W  = 2;   // req_type
  localparam int OUT_DATA_W = 40;  // row_bits, all_dead, filled up to whole bytes

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_SET   = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // Command broadcast to every row cell
  typedef struct packed {
    logic en;
    req_t op;
  } row_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/lgs_row_cell.sv -----
// One row cell of the life grid: holds one row and computes its next generation.
// Takes the rows above and below from its neighbors every cycle; depends on lgs_pkg.
`default_nettype none

module lgs_row_cell #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lgs_pkg::row_cmd_t    cmd,
  input  wire logic                 sel,
  input  wire logic [GRID_SIZE-1:0] set_mask,
  input  wire logic [GRID_SIZE-1:0] up_row,
  input  wire logic [GRID_SIZE-1:0] dn_row,
  output logic      [GRID_SIZE-1:0] row_o,
  output logic                      live_o
);
  import lgs_pkg::*;

  logic [GRID_SIZE-1:0] row_r, row_nxt;
  logic                 live_r;
  logic [GRID_SIZE-1:0] life_row;
  logic [GRID_SIZE+1:0] up_x, own_x, dn_x;

  // Pad with dead cells beyond the grid edge
  assign up_x  = {1'b0, up_row, 1'b0};
  assign own_x = {1'b0, row_r, 1'b0};
  assign dn_x  = {1'b0, dn_row, 1'b0};

  // Count eight neighbors per column and apply B3/S23
  always_comb begin : life_calc
    logic [3:0] n;
    n = '0;
    life_row = '0;
    for (int c = 0; c < GRID_SIZE; c++) begin
      n = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
        + 4'(own_x[c]) + 4'(own_x[c+2])
        + 4'(dn_x[c]) + 4'(dn_x[c+1]) + 4'(dn_x[c+2]);
      life_row[c] = (n == 4'd3) || (row_r[c] && (n == 4'd2));
    end
  end

  // Select the next row contents from the command
  always_comb begin
    row_nxt = row_r;
    if (cmd.en) begin
      case (cmd.op)
        REQ_CLEAR: row_nxt = '0;
        REQ_SET:   row_nxt = sel ? (row_r | set_mask) : row_r;
        REQ_STEP:  row_nxt = life_row;
        REQ_READ:  row_nxt = row_r;
        default:   row_nxt = row_r;
      endcase
    end
  end

  // Hold the row and its any-alive flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      live_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      live_r <= |row_nxt;
    end
  end

  assign row_o  = row_r;
  assign live_o = live_r;

endmodule

`default_nettype wire

// ----- rtl/core/life_grid_generation_step.sv -----
// Life grid generation step (Conway B3/S23) built as a column of row cells.
// Channels: in_* takes one request item: in_tuser holds req_type (clear, set
//   cell, advance one generation, read row), in_tdata holds row and col.
//   out_* returns one item per request: row_bits (zero unless a read) and
//   all_dead, the grid-empty flag after the request.
// Every row cell updates its whole row in the cycle the item is accepted, so
//   the full grid advances one generation at once.
// The result passes through a pending stage that gathers the row flags, then
//   the output register, before it shows on out_tvalid.
// Throughput: one item per cycle while out_tready stays high; the pending
//   stage lets a new item in while a result waits in the output register.
// Stall: when out_tready is low and both stages are full, in_tready drops and
//   grid and results hold.
// Reset (synchronous, rst_n low): all cells dead, both stages empty.
// Depends on lgs_pkg and lgs_row_cell.
`default_nettype none

module life_grid_generation_step #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lgs_pkg::IN_DATA_W-1:0]  in_tdata,   // [4:0] row, [9:5] col, [15:10] zero
  input  wire logic [lgs_pkg::IN_USER_W-1:0]  in_tuser,   // [1:0] req_type
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [lgs_pkg::OUT_DATA_W-1:0] out_tdata   // [31:0] row_bits, [32] all_dead,
                                                          // [39:33] zero
);
  import lgs_pkg::*;

  localparam int RD_ROWS = (GRID_SIZE < ROW_OUT_W) ? GRID_SIZE : ROW_OUT_W;
  localparam int RD_COLS = (GRID_SIZE < ROW_OUT_W) ? GRID_SIZE : ROW_OUT_W;

  logic [IDX_W-1:0]     in_row, in_col;
  req_t                 in_req;
  logic                 accept;
  row_cmd_t             cmd;
  logic [GRID_SIZE-1:0] set_mask;
  logic [GRID_SIZE-1:0] row_sel;
  logic [GRID_SIZE-1:0] grid_w [GRID_SIZE];
  logic [GRID_SIZE-1:0] live_w;
  logic [ROW_OUT_W-1:0] rd_bits;
  logic                 set_ok;

  logic                 pend_r, pend_nxt;
  logic [ROW_OUT_W-1:0] pend_bits_r, pend_bits_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_OUT_W-1:0] out_bits_r, out_bits_nxt;
  logic                 out_dead_r, out_dead_nxt;
  logic                 out_free;

  // Unpack the request item
  assign in_row = in_tdata[IDX_W-1:0];
  assign in_col = in_tdata[2*IDX_W-1:IDX_W];
  assign in_req = req_t'(in_tuser);

  // Take an item while the pending stage is empty or drains this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !pend_r || out_free;
  assign accept    = in_tvalid && in_tready;

  assign cmd.en = accept;
  assign cmd.op = in_req;

  assign set_ok = ({2'b00, in_row} < 7'(GRID_SIZE)) && ({2'b00, in_col} < 7'(GRID_SIZE));

  // Decode column mask and row select for a set
  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_mask
    if (c < ROW_OUT_W) begin : g_addr
      assign set_mask[c] = (in_col == IDX_W'(c));
      assign row_sel[c]  = set_ok && (in_row == IDX_W'(c));
    end else begin : g_far
      assign set_mask[c] = 1'b0;
      assign row_sel[c]  = 1'b0;
    end
  end

  // Column of row cells, each fed by its upper and lower neighbor
  for (genvar r = 0; r < GRID_SIZE; r++) begin : g_cell
    logic [GRID_SIZE-1:0] up_row, dn_row;
    if (r == 0) begin : g_top
      assign up_row = '0;
    end else begin : g_up
      assign up_row = grid_w[r-1];
    end
    if (r == GRID_SIZE - 1) begin : g_bot
      assign dn_row = '0;
    end else begin : g_dn
      assign dn_row = grid_w[r+1];
    end

    lgs_row_cell #(
      .GRID_SIZE (GRID_SIZE)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (row_sel[r]),
      .set_mask (set_mask),
      .up_row   (up_row),
      .dn_row   (dn_row),
      .row_o    (grid_w[r]),
      .live_o   (live_w[r])
    );
  end

  // Read the addressed row before the grid changes
  always_comb begin
    rd_bits = '0;
    if (in_req == REQ_READ) begin
      for (int r = 0; r < RD_ROWS; r++) begin
        if (in_row == IDX_W'(r)) begin
          rd_bits[RD_COLS-1:0] = grid_w[r][RD_COLS-1:0];
        end
      end
    end
  end

  // Advance the pending and output stages
  always_comb begin
    pend_nxt      = pend_r;
    pend_bits_nxt = pend_bits_r;
    out_valid_nxt = out_valid_r;
    out_bits_nxt  = out_bits_r;
    out_dead_nxt  = out_dead_r;
    if (out_free) begin
      out_valid_nxt = pend_r;
      if (pend_r) begin
        out_bits_nxt = pend_bits_r;
        out_dead_nxt = ~|live_w;
      end
      pend_nxt = 1'b0;
    end
    if (accept) begin
      pend_nxt      = 1'b1;
      pend_bits_nxt = rd_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    pend_bits_r <= pend_bits_nxt;
    out_bits_r  <= out_bits_nxt;
    out_dead_r  <= out_dead_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - ROW_OUT_W - 1)'(0), out_dead_r, out_bits_r};

endmodule

`default_nettype wire

// ----- rtl/core/lgs_checker.sv -----
// Port-level checker for life_grid_generation_step, attached by bind.
// Watches only the top-level ports; depends on lgs_pkg.
`default_nettype none

module lgs_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [lgs_pkg::IN_DATA_W-1:0]  in_tdata,
  input wire logic [lgs_pkg::IN_USER_W-1:0]  in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [lgs_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lgs_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Offered item holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input item changed while waiting");

  // Input backpressure only when a result is stuck at the output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // A live row in a read result contradicts an empty grid
  a_dead_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[ROW_OUT_W-1:0] != '0) |-> !out_tdata[ROW_OUT_W])
    else $error("all_dead set with live cells in row");

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("stages not empty after reset");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (.*);

`default_nettype wire
